@@ src/blad_pkg.sv @@
// Shared types, constants and helpers of the bob line-average deinterlacer.
package blad_pkg;

    localparam int BYTE_W        = 8;
    localparam int OUT_ROW_W     = 12;
    localparam int OUT_COL_W     = 13;
    localparam int LINE_BYTES_W  = 14;
    localparam int LINE_COUNT_W  = 13;
    localparam int CFG_DATA_W    = 14;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_FIELD_FIRST = 2'd2;

    localparam int DEF_MAX_LINE_BYTES = 8192;
    localparam int DEF_MAX_LINES      = 4096;
    localparam int RESET_LINE_BYTES   = 7680;
    localparam int RESET_LINE_COUNT   = 1080;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic [BYTE_W-1:0]    byte_val;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] column;
        logic                 done;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0)
            r = 32'd1;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ src/bob_line_average_deinterlacer_core.sv @@
// Top level of the bob line-average deinterlacer.
//
// Takes frame bytes in raster order and tracks row and column from line_bytes
// and line_count. Each byte of row r releases the byte of row r-1 at the same
// column: a copy for a kept-field row or row 0, otherwise the truncated mean of
// rows r-2 and r. Bytes of the last row also pass straight through as their own
// transaction, flagged by frame_done on the last column. The two previous lines
// sit in two line stores with registered reads; a byte is read at accept,
// combined and written back the next cycle, with forwarding when the same column
// comes back at once. Rate: one byte per clock unless in_stall holds input, on
// every row that releases one transaction per byte; on the last row of a frame
// taller than one line each byte releases two, and the one-per-clock output
// queue then holds input back. Results pass the stage-1 registers, then the
// output queue. Line store contents are unknown after reset until a full frame
// has passed; there is no clearing pass.
module bob_line_average_deinterlacer_core #(
    parameter int MAX_LINE_BYTES = blad_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_LINES      = blad_pkg::DEF_MAX_LINES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [blad_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [blad_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [blad_pkg::BYTE_W-1:0]       pixel_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [blad_pkg::BYTE_W-1:0]       out_byte,
    output logic [blad_pkg::OUT_ROW_W-1:0]    out_row,
    output logic [blad_pkg::OUT_COL_W-1:0]    out_column,
    output logic                              frame_done
);
    import blad_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_BYTES);
    localparam int WID_W = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_LINES);
    localparam int HGT_W = ROW_W + 1;

    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic             top_first;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             accept;
    logic             wrap_col;
    logic [COL_W-1:0] c_cur;
    logic [HGT_W-1:0] r_inc;
    logic [ROW_W-1:0] r_cur;
    logic [WID_W-1:0] c_plus;
    logic [HGT_W-1:0] r_plus;
    logic             end_line;
    logic             end_frame;

    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [BYTE_W-1:0] s1_px_reg;
    logic              s1_has_above_reg;
    logic              s1_copy_reg;
    logic              s1_last_row_reg;
    logic              s1_done_reg;
    logic              s1_fwd_reg;
    logic [BYTE_W-1:0] fwd_prev_reg;
    logic [BYTE_W-1:0] fwd_older_reg;

    logic [BYTE_W-1:0] prev_rd;
    logic [BYTE_W-1:0] older_rd;
    logic [BYTE_W-1:0] prev_eff;
    logic [BYTE_W-1:0] older_eff;
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] above_val;
    logic [ROW_W-1:0]  above_row;
    result_t           res_above;
    result_t           res_pass;
    push_t             push;
    result_t           head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   reserved;

    blad_cfg #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_LINES      (MAX_LINES),
        .WID_W          (WID_W),
        .HGT_W          (HGT_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .width     (width),
        .height    (height),
        .top_first (top_first)
    );

    // hold input while the queue cannot take the worst case in flight
    assign reserved = {1'b0, fifo_count} + (s1_valid_reg ? (FIFO_CNT_W+1)'(2) : '0);
    assign in_stall = (reserved > (FIFO_CNT_W+1)'(FIFO_DEPTH - 2));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        wrap_col  = ({1'b0, col_reg} >= width);
        c_cur     = wrap_col ? '0 : col_reg;
        r_inc     = {1'b0, row_reg} + HGT_W'(wrap_col);
        r_cur     = (r_inc >= height) ? '0 : r_inc[ROW_W-1:0];
        c_plus    = {1'b0, c_cur} + WID_W'(1);
        r_plus    = {1'b0, r_cur} + HGT_W'(1);
        end_line  = (c_plus >= width);
        end_frame = (r_plus >= height);
        col_next  = end_line ? '0 : c_plus[COL_W-1:0];
        if (end_line)
            row_next = end_frame ? '0 : r_plus[ROW_W-1:0];
        else
            row_next = r_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= c_cur;
            s1_row_reg       <= r_cur;
            s1_px_reg        <= pixel_byte;
            s1_has_above_reg <= (r_cur != '0);
            s1_copy_reg      <= (r_cur == ROW_W'(1)) || (r_cur[0] == top_first);
            s1_last_row_reg  <= end_frame;
            s1_done_reg      <= end_frame && end_line;
            s1_fwd_reg       <= s1_valid_reg && (s1_col_reg == c_cur);
            fwd_prev_reg     <= s1_px_reg;
            fwd_older_reg    <= prev_eff;
        end
    end

    blad_line_mem #(
        .DEPTH  (MAX_LINE_BYTES),
        .ADDR_W (COL_W)
    ) u_prev_mem (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_px_reg),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (prev_rd)
    );

    blad_line_mem #(
        .DEPTH  (MAX_LINE_BYTES),
        .ADDR_W (COL_W)
    ) u_older_mem (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (prev_eff),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (older_rd)
    );

    always_comb
    begin
        prev_eff  = s1_fwd_reg ? fwd_prev_reg : prev_rd;
        older_eff = s1_fwd_reg ? fwd_older_reg : older_rd;
        sum       = {1'b0, older_eff} + {1'b0, s1_px_reg};
        above_val = s1_copy_reg ? prev_eff : sum[BYTE_W:1];
        above_row = s1_row_reg - ROW_W'(1);

        res_above.byte_val = above_val;
        res_above.row      = OUT_ROW_W'(above_row);
        res_above.column   = OUT_COL_W'(s1_col_reg);
        res_above.done     = 1'b0;

        res_pass.byte_val  = s1_px_reg;
        res_pass.row       = OUT_ROW_W'(s1_row_reg);
        res_pass.column    = OUT_COL_W'(s1_col_reg);
        res_pass.done      = s1_done_reg;

        push.count  = 2'd0;
        push.first  = res_above;
        push.second = res_pass;
        if (s1_valid_reg)
        begin
            if (s1_has_above_reg)
                push.count = s1_last_row_reg ? 2'd2 : 2'd1;
            else if (s1_last_row_reg)
            begin
                push.count = 2'd1;
                push.first = res_pass;
            end
        end
    end

    blad_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign out_byte   = head.byte_val;
    assign out_row    = head.row;
    assign out_column = head.column;
    assign frame_done = head.done;

endmodule

@@ src/blad_cfg.sv @@
// Configuration registers with clamped frame geometry.
module blad_cfg #(
    parameter int MAX_LINE_BYTES = blad_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_LINES      = blad_pkg::DEF_MAX_LINES,
    parameter int WID_W          = $clog2(MAX_LINE_BYTES) + 1,
    parameter int HGT_W          = $clog2(MAX_LINES) + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [blad_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [blad_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [WID_W-1:0]                   width,
    output logic [HGT_W-1:0]                   height,
    output logic                               top_first
);
    import blad_pkg::*;

    localparam logic [WID_W-1:0] WIDTH_RESET =
        WID_W'(clamp_size(32'(RESET_LINE_BYTES), 32'(MAX_LINE_BYTES)));
    localparam logic [HGT_W-1:0] HEIGHT_RESET =
        HGT_W'(clamp_size(32'(RESET_LINE_COUNT), 32'(MAX_LINES)));

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             top_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            top_first_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LINE_BYTES:
                    width_reg <= WID_W'(clamp_size(32'(cfg_data[LINE_BYTES_W-1:0]),
                                                   32'(MAX_LINE_BYTES)));
                REG_LINE_COUNT:
                    height_reg <= HGT_W'(clamp_size(32'(cfg_data[LINE_COUNT_W-1:0]),
                                                    32'(MAX_LINES)));
                REG_TOP_FIELD_FIRST:
                    top_first_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign width     = width_reg;
    assign height    = height_reg;
    assign top_first = top_first_reg;

endmodule

@@ src/blad_line_mem.sv @@
// Line store: one write port, one registered read port.
module blad_line_mem #(
    parameter int DEPTH  = blad_pkg::DEF_MAX_LINE_BYTES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [blad_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [blad_pkg::BYTE_W-1:0] rd_data
);
    import blad_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/blad_out_fifo.sv @@
// Output queue taking up to two results per cycle, releasing one unless out_stall is high.
module blad_out_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blad_pkg::push_t                   push,
    input  logic                              out_stall,
    output logic                              out_valid,
    output blad_pkg::result_t                 head,
    output logic [blad_pkg::FIFO_CNT_W-1:0]   count
);
    import blad_pkg::*;

    result_t               entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign pop = (count_reg != '0) && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

    assign out_valid = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

endmodule

@@ tb/bob_line_average_deinterlacer_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking randomized testbench of the bob line-average deinterlacer core.
module bob_line_average_deinterlacer_core_tb;
    import blad_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_write  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = REG_LINE_BYTES;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      pixel_byte = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [BYTE_W-1:0]      out_byte;
    logic [OUT_ROW_W-1:0]   out_row;
    logic [OUT_COL_W-1:0]   out_column;
    logic                   frame_done;

    logic [BYTE_W-1:0]       two_up_line [DEF_MAX_LINE_BYTES];
    logic [BYTE_W-1:0]       one_up_line [DEF_MAX_LINE_BYTES];
    int unsigned             scan_row = 0;
    int unsigned             scan_col = 0;
    logic [LINE_BYTES_W-1:0] set_line_bytes = LINE_BYTES_W'(RESET_LINE_BYTES);
    logic [LINE_COUNT_W-1:0] set_line_count = LINE_COUNT_W'(RESET_LINE_COUNT);
    logic                    set_top_first = 1'b1;
    result_t                 deinterlaced_due [$];

    int unsigned idle_pct     = 25;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    int unsigned pixels_sent  = 0;
    int unsigned bytes_seen   = 0;
    int unsigned frames_sent  = 0;
    int unsigned writes_done  = 0;

    bob_line_average_deinterlacer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_row    (out_row),
        .out_column (out_column),
        .frame_done (frame_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic bob_predict(input logic [BYTE_W-1:0] px);
        int unsigned width;
        int unsigned height;
        int unsigned above;
        int unsigned kept;
        logic [BYTE_W:0] sum;
        logic [OUT_COL_W-1:0] col_at;
        result_t res;
        width = (set_line_bytes == 0) ? 1 :
                (set_line_bytes > DEF_MAX_LINE_BYTES) ? DEF_MAX_LINE_BYTES : set_line_bytes;
        height = (set_line_count == 0) ? 1 :
                 (set_line_count > DEF_MAX_LINES) ? DEF_MAX_LINES : set_line_count;
        if (scan_col >= width)
        begin
            scan_col = 0;
            scan_row++;
        end
        if (scan_row >= height)
            scan_row = 0;
        col_at = OUT_COL_W'(scan_col);
        kept = set_top_first ? 0 : 1;
        if (scan_row >= 1)
        begin
            above = scan_row - 1;
            res.row = OUT_ROW_W'(above);
            res.column = OUT_COL_W'(scan_col);
            res.done = 1'b0;
            if (above == 0 || (above & 1) == kept)
                res.byte_val = one_up_line[col_at];
            else
            begin
                sum = {1'b0, two_up_line[col_at]} + {1'b0, px};
                res.byte_val = sum[BYTE_W:1];
            end
            deinterlaced_due.push_back(res);
        end
        if (scan_row == height - 1)
        begin
            res.byte_val = px;
            res.row = OUT_ROW_W'(scan_row);
            res.column = OUT_COL_W'(scan_col);
            res.done = (scan_col == width - 1);
            deinterlaced_due.push_back(res);
        end
        two_up_line[col_at] = one_up_line[col_at];
        one_up_line[col_at] = px;
        scan_col++;
        if (scan_col >= width)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= height)
                scan_row = 0;
        end
    endtask

    task automatic note_mismatch(input string what, input result_t want);
        if (mismatches < 10)
            $display({"Mismatch (%s): expected byte=%0d row=%0d col=%0d done=%0d,",
                      " got byte=%0d row=%0d col=%0d done=%0d"},
                     what, want.byte_val, want.row, want.column, want.done,
                     out_byte, out_row, out_column, frame_done);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_seen++;
            if (deinterlaced_due.size() == 0)
                note_mismatch("no transaction expected", '0);
            else
            begin
                want = deinterlaced_due.pop_front();
                if (out_byte !== want.byte_val || out_row !== want.row ||
                    out_column !== want.column || frame_done !== want.done)
                    note_mismatch("field", want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(1, 7);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: %0d cycles without a transaction", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input logic [BYTE_W-1:0] value);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_byte <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bob_predict(value);
        pixels_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (deinterlaced_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LINE_BYTES:      set_line_bytes = value[LINE_BYTES_W-1:0];
            REG_LINE_COUNT:      set_line_count = value[LINE_COUNT_W-1:0];
            REG_TOP_FIELD_FIRST: set_top_first = value[0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic set_format(input int unsigned bytes, input int unsigned lines,
                              input bit top_first);
        settle();
        write_register(REG_LINE_BYTES, bytes);
        write_register(REG_LINE_COUNT, lines);
        write_register(REG_TOP_FIELD_FIRST, 32'(top_first));
    endtask

    task automatic finish_frame();
        do
            send_pixel(BYTE_W'($urandom_range(0, 255)));
        while (scan_row != 0 || scan_col != 0);
        frames_sent++;
    endtask

    task automatic test_reset_defaults();
        repeat (4) send_pixel(BYTE_W'($urandom_range(0, 255)));
        set_format(2, 3, 1'b1);
        finish_frame();
    endtask

    task automatic test_field_patterns();
        logic [BYTE_W-1:0] top_frame [12] = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F,
                                             8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFE};
        logic [BYTE_W-1:0] bottom_frame [8] = '{8'h00, 8'hFF, 8'hFF, 8'hFF,
                                               8'h80, 8'h00, 8'hFF, 8'h01};
        set_format(3, 4, 1'b1);
        foreach (top_frame[i])
            send_pixel(top_frame[i]);
        frames_sent++;
        set_format(2, 4, 1'b0);
        foreach (bottom_frame[i])
            send_pixel(bottom_frame[i]);
        frames_sent++;
    endtask

    task automatic test_degenerate_sizes();
        set_format(0, 3, 1'b1);
        finish_frame();
        set_format(2, 0, 1'b0);
        finish_frame();
    endtask

    task automatic test_frame_restart();
        set_format(2, 3, 1'b1);
        repeat (4) send_pixel(BYTE_W'($urandom_range(0, 255)));
        settle();
        write_register(REG_LINE_COUNT, 2);
        finish_frame();
    endtask

    task automatic test_largest_sizes();
        idle_pct = 20;
        set_format(16383, 8191, 1'b1);
        repeat (40) send_pixel(BYTE_W'($urandom_range(0, 255)));
        set_format(DEF_MAX_LINE_BYTES, 1, 1'b0);
        repeat (40) send_pixel(BYTE_W'($urandom_range(0, 255)));
        set_format(2, 3, 1'b1);
        finish_frame();
    endtask

    task automatic test_random_frames(input int unsigned quota, input bit calm);
        int unsigned start;
        int unsigned bytes;
        start = pixels_sent;
        while (pixels_sent - start < quota)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (calm)
                idle_pct = 0;
            bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 10);
            set_format(bytes, $urandom_range(1, 8), 1'($urandom_range(0, 1)));
            finish_frame();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_patterns();
        test_degenerate_sizes();
        test_frame_restart();
        test_largest_sizes();
        test_random_frames(880, 1'b0);
        test_random_frames(120, 1'b1);
        settle();
        $display("Sent %0d input bytes in %0d frames with %0d register writes; checked %0d outputs.",
                 pixels_sent, frames_sent, writes_done, bytes_seen);
        $display({"Covered both field orders, zero and oversized geometry settings, ",
                  "restart on a shrunk frame and random frames up to 64 by 8."});
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/blad_pkg.sv
src/blad_cfg.sv
src/blad_line_mem.sv
src/blad_out_fifo.sv
src/bob_line_average_deinterlacer_core.sv
tb/bob_line_average_deinterlacer_core_tb.sv
